[rtl/core/paf_pkg.sv]
// Shared constants, codes and control structs for the polygon area filter and sum.
// No dependencies; compiled first.
package paf_pkg;

  // Default geometry and accumulator sizing (top-level parameter defaults)
  localparam int unsigned COORD_BITS   = 16;
  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned SUM_BITS     = 48;

  // Fixed result field widths
  localparam int unsigned AREA_BITS    = 40;
  localparam int unsigned TOTAL_BITS   = 48;
  localparam int unsigned VCNT_BITS    = 11;
  localparam int unsigned SETCNT_BITS  = 16;
  localparam int unsigned VCNT_LIMIT   = 2047;

  // Configuration port
  localparam int unsigned MODE_BITS     = 2;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 11;

  localparam logic [AREA_BITS-1:0]   AREA_MAX   = '1;
  localparam logic [SETCNT_BITS-1:0] SETCNT_MAX = '1;

  typedef enum logic [MODE_BITS-1:0] {
    SEL_EVEN  = 2'd0,
    SEL_ODD   = 2'd1,
    SEL_ALL   = 2'd2,
    SEL_EXACT = 2'd3
  } sel_mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SELECT_MODE    = 1'd0,
    CFG_MATCH_VERTICES = 1'd1
  } cfg_reg_e;

  localparam sel_mode_e            MODE_RESET  = SEL_ALL;
  localparam logic [VCNT_BITS-1:0] MATCH_RESET = 11'd3;

  // Per-vertex control carried alongside the cross-product pipeline
  typedef struct packed {
    logic start;   // first vertex of a polygon
    logic pend;    // closes the polygon
    logic send;    // closes the set
  } vtx_flags_t;

  // Control leaving the shoelace accumulator
  typedef struct packed {
    logic pend;
    logic send;
    logic sat;     // a cross sum or vertex count saturated on this vertex
  } acc_flags_t;

endpackage

[rtl/core/paf_if.sv]
// Valid/ready channel interfaces: vertex input, polygon result and config write.
// Depends on paf_pkg.
interface paf_in_if #(
  parameter int unsigned CoordBits = paf_pkg::COORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] x_coord;
  logic signed [CoordBits-1:0] y_coord;
  logic                        polygon_end;
  logic                        set_end;

  modport source (output valid, x_coord, y_coord, polygon_end, set_end, input ready);
  modport sink   (input valid, x_coord, y_coord, polygon_end, set_end, output ready);
endinterface

interface paf_out_if;
  logic                                valid;
  logic                                ready;
  logic [paf_pkg::AREA_BITS-1:0]       polygon_double_area;
  logic [paf_pkg::VCNT_BITS-1:0]       polygon_vertices;
  logic                                polygon_selected;
  logic [paf_pkg::TOTAL_BITS-1:0]      total_double_area;
  logic [paf_pkg::SETCNT_BITS-1:0]     selected_total;
  logic [paf_pkg::SETCNT_BITS-1:0]     polygon_total;
  logic                                final_result;
  logic                                overflow_flag;

  modport source (output valid, polygon_double_area, polygon_vertices, polygon_selected,
                  total_double_area, selected_total, polygon_total, final_result,
                  overflow_flag, input ready);
  modport sink   (input valid, polygon_double_area, polygon_vertices, polygon_selected,
                  total_double_area, selected_total, polygon_total, final_result,
                  overflow_flag, output ready);
endinterface

interface paf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [paf_pkg::CFG_IDX_BITS-1:0]    index;
  logic [paf_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/paf_cross.sv]
// Vertex front end: first/previous vertex tracking, input register, product and
// cross-term stages. Depends on paf_pkg.
module paf_cross #(
  parameter int unsigned CoordBits = paf_pkg::COORD_BITS,
  localparam int unsigned CrossBits = 2 * CoordBits + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [CoordBits-1:0] x_i,
  input  logic signed [CoordBits-1:0] y_i,
  input  logic                        pend_i,
  input  logic                        send_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output paf_pkg::vtx_flags_t         flags_o,
  output logic signed [CrossBits-1:0] c_prev_o,
  output logic signed [CrossBits-1:0] c_close_o
);

  localparam int unsigned ProdBits = 2 * CoordBits;

  logic                        start_q;
  logic signed [CoordBits-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;

  logic                        s1_vld_q, s2_vld_q, s3_vld_q;
  logic                        s1_rdy, s2_rdy, s3_rdy, in_take;

  logic signed [CoordBits-1:0] s1_x_q, s1_y_q, s1_px_q, s1_py_q, s1_fx_q, s1_fy_q;
  paf_pkg::vtx_flags_t         s1_flags_q, s2_flags_q, s3_flags_q;

  logic signed [ProdBits-1:0]  p_a_q, p_b_q, p_c_q, p_d_q;
  logic signed [CrossBits-1:0] c_prev_q, c_close_q;

  assign s3_rdy     = !s3_vld_q || out_ready_i;
  assign s2_rdy     = !s2_vld_q || s3_rdy;
  assign s1_rdy     = !s1_vld_q || s2_rdy;
  assign in_ready_o = s1_rdy;
  assign in_take    = in_valid_i && s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= 1'b1;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (in_take) start_q <= pend_i;
      if (s1_rdy)  s1_vld_q <= in_valid_i;
      if (s2_rdy)  s2_vld_q <= s1_vld_q;
      if (s3_rdy)  s3_vld_q <= s2_vld_q;
    end
  end

  // first vertex of a polygon pairs with itself, so its closing term is zero
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      prev_x_q         <= x_i;
      prev_y_q         <= y_i;
      if (start_q) begin
        first_x_q <= x_i;
        first_y_q <= y_i;
      end
      s1_x_q           <= x_i;
      s1_y_q           <= y_i;
      s1_px_q          <= prev_x_q;
      s1_py_q          <= prev_y_q;
      s1_fx_q          <= start_q ? x_i : first_x_q;
      s1_fy_q          <= start_q ? y_i : first_y_q;
      s1_flags_q.start <= start_q;
      s1_flags_q.pend  <= pend_i;
      s1_flags_q.send  <= send_i;
    end
    if (s2_rdy && s1_vld_q) begin
      p_a_q      <= ProdBits'(s1_px_q) * ProdBits'(s1_y_q);
      p_b_q      <= ProdBits'(s1_py_q) * ProdBits'(s1_x_q);
      p_c_q      <= ProdBits'(s1_x_q) * ProdBits'(s1_fy_q);
      p_d_q      <= ProdBits'(s1_y_q) * ProdBits'(s1_fx_q);
      s2_flags_q <= s1_flags_q;
    end
    if (s3_rdy && s2_vld_q) begin
      c_prev_q   <= CrossBits'(p_a_q) - CrossBits'(p_b_q);
      c_close_q  <= CrossBits'(p_c_q) - CrossBits'(p_d_q);
      s3_flags_q <= s2_flags_q;
    end
  end

  assign out_valid_o = s3_vld_q;
  assign flags_o     = s3_flags_q;
  assign c_prev_o    = c_prev_q;
  assign c_close_o   = c_close_q;

endmodule

[rtl/core/paf_accum.sv]
// Shoelace accumulator: saturating signed cross sum and vertex counter per polygon.
// Depends on paf_pkg.
module paf_accum #(
  parameter int unsigned CoordBits   = paf_pkg::COORD_BITS,
  parameter int unsigned SumBits     = paf_pkg::SUM_BITS,
  parameter int unsigned MaxVertices = paf_pkg::MAX_VERTICES,
  localparam int unsigned CrossBits  = 2 * CoordBits + 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  paf_pkg::vtx_flags_t                  flags_i,
  input  logic signed [CrossBits-1:0]          c_prev_i,
  input  logic signed [CrossBits-1:0]          c_close_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output paf_pkg::acc_flags_t                  flags_o,
  output logic signed [SumBits-1:0]            sum_o,
  output logic [paf_pkg::VCNT_BITS-1:0]        vcnt_o
);

  localparam int unsigned WideBits = (SumBits > CrossBits ? SumBits : CrossBits) + 1;
  localparam logic signed [WideBits-1:0] SumHi =
    {{(WideBits - SumBits + 1){1'b0}}, {(SumBits - 1){1'b1}}};
  localparam logic signed [WideBits-1:0] SumLo = ~SumHi;
  localparam logic [paf_pkg::VCNT_BITS-1:0] VcntMax = paf_pkg::VCNT_BITS'(
    MaxVertices < paf_pkg::VCNT_LIMIT ? MaxVertices : paf_pkg::VCNT_LIMIT);

  // {saturated, value}
  function automatic logic [SumBits:0] sat_add(input logic signed [SumBits-1:0]   a,
                                               input logic signed [CrossBits-1:0] b);
    logic signed [WideBits-1:0] s;
    s = WideBits'(a) + WideBits'(b);
    if (s > SumHi)      return {1'b1, SumHi[SumBits-1:0]};
    else if (s < SumLo) return {1'b1, SumLo[SumBits-1:0]};
    else                return {1'b0, s[SumBits-1:0]};
  endfunction

  logic                             vld_q, take;
  logic signed [SumBits-1:0]        sum_q, sum_d, part_sum;
  logic [paf_pkg::VCNT_BITS-1:0]    vcnt_q, vcnt_d;
  logic [SumBits:0]                 step_prev, step_close;
  logic                             sat_prev, sat_close, sat_vcnt;
  paf_pkg::acc_flags_t              flags_q;

  assign in_ready_o = !vld_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    step_prev  = sat_add(sum_q, c_prev_i);
    part_sum   = flags_i.start ? '0 : step_prev[SumBits-1:0];
    sat_prev   = !flags_i.start && step_prev[SumBits];
    step_close = sat_add(part_sum, c_close_i);
    sum_d      = flags_i.pend ? step_close[SumBits-1:0] : part_sum;
    sat_close  = flags_i.pend && step_close[SumBits];

    sat_vcnt = 1'b0;
    if (flags_i.start) begin
      vcnt_d = paf_pkg::VCNT_BITS'(1);
    end else if (vcnt_q < VcntMax) begin
      vcnt_d = vcnt_q + paf_pkg::VCNT_BITS'(1);
    end else begin
      vcnt_d   = vcnt_q;
      sat_vcnt = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sum_q        <= sum_d;
      vcnt_q       <= vcnt_d;
      flags_q.pend <= flags_i.pend;
      flags_q.send <= flags_i.send;
      flags_q.sat  <= sat_prev || sat_close || sat_vcnt;
    end
  end

  assign out_valid_o = vld_q;
  assign flags_o     = flags_q;
  assign sum_o       = sum_q;
  assign vcnt_o      = vcnt_q;

endmodule

[rtl/core/paf_total.sv]
// Area magnitude, polygon selection, set totals and the result register.
// Depends on paf_pkg.
module paf_total #(
  parameter int unsigned SumBits = paf_pkg::SUM_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  paf_pkg::acc_flags_t                flags_i,
  input  logic signed [SumBits-1:0]          sum_i,
  input  logic [paf_pkg::VCNT_BITS-1:0]      vcnt_i,
  input  paf_pkg::sel_mode_e                 mode_i,
  input  logic [paf_pkg::VCNT_BITS-1:0]      match_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [paf_pkg::AREA_BITS-1:0]      area_o,
  output logic [paf_pkg::VCNT_BITS-1:0]      vcnt_o,
  output logic                               selected_o,
  output logic [paf_pkg::TOTAL_BITS-1:0]     total_o,
  output logic [paf_pkg::SETCNT_BITS-1:0]    chosen_o,
  output logic [paf_pkg::SETCNT_BITS-1:0]    seen_o,
  output logic                               final_o,
  output logic                               overflow_o
);

  localparam int unsigned TotBits = paf_pkg::TOTAL_BITS;
  localparam int unsigned CntBits = paf_pkg::SETCNT_BITS;
  localparam int unsigned TotUsed = SumBits < TotBits ? SumBits : TotBits;
  localparam logic [TotBits-1:0] TotalMax =
    (TotBits'(1) << TotUsed) - TotBits'(1);

  logic                              take;
  logic [SumBits-1:0]                abs_val;
  logic [63:0]                       abs_wide;
  logic [paf_pkg::AREA_BITS-1:0]     mag;
  logic                              mag_sat, chosen, tot_sat, event_sat;
  logic [TotBits:0]                  tot_sum;
  logic [TotBits-1:0]                total_q, total_d;
  logic [CntBits-1:0]                chosen_q, chosen_d, seen_q, seen_d;
  logic                              sat_q;

  logic                              out_vld_q;
  logic [paf_pkg::AREA_BITS-1:0]     area_q;
  logic [paf_pkg::VCNT_BITS-1:0]     vcnt_q;
  logic                              selected_q, final_q, overflow_q;
  logic [TotBits-1:0]                total_out_q;
  logic [CntBits-1:0]                chosen_out_q, seen_out_q;

  // a plain vertex carries only saturation news and never waits on the result slot
  assign in_ready_o = !in_valid_i || !flags_i.pend || !out_vld_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    abs_val  = sum_i[SumBits-1] ? SumBits'(-sum_i) : SumBits'(sum_i);
    abs_wide = 64'(abs_val);
    mag_sat  = abs_wide > 64'(paf_pkg::AREA_MAX);
    mag      = mag_sat ? paf_pkg::AREA_MAX : abs_wide[paf_pkg::AREA_BITS-1:0];

    case (mode_i)
      paf_pkg::SEL_EVEN: chosen = !vcnt_i[0];
      paf_pkg::SEL_ODD:  chosen = vcnt_i[0];
      paf_pkg::SEL_ALL:  chosen = 1'b1;
      default:           chosen = (vcnt_i == match_i);
    endcase

    event_sat = flags_i.sat || mag_sat;

    if (seen_q != paf_pkg::SETCNT_MAX) begin
      seen_d = seen_q + CntBits'(1);
    end else begin
      seen_d    = seen_q;
      event_sat = 1'b1;
    end

    tot_sum  = (TotBits + 1)'(total_q) + (TotBits + 1)'(mag);
    tot_sat  = 1'b0;
    total_d  = total_q;
    chosen_d = chosen_q;
    if (chosen) begin
      if (tot_sum > (TotBits + 1)'(TotalMax)) begin
        total_d = TotalMax;
        tot_sat = 1'b1;
      end else begin
        total_d = tot_sum[TotBits-1:0];
      end
      if (chosen_q != paf_pkg::SETCNT_MAX) begin
        chosen_d = chosen_q + CntBits'(1);
      end else begin
        event_sat = 1'b1;
      end
    end
    event_sat = event_sat || tot_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      total_q   <= '0;
      chosen_q  <= '0;
      seen_q    <= '0;
      sat_q     <= 1'b0;
    end else begin
      if (take && flags_i.pend) begin
        out_vld_q <= 1'b1;
        if (flags_i.send) begin
          total_q  <= '0;
          chosen_q <= '0;
          seen_q   <= '0;
          sat_q    <= 1'b0;
        end else begin
          total_q  <= total_d;
          chosen_q <= chosen_d;
          seen_q   <= seen_d;
          sat_q    <= sat_q || event_sat;
        end
      end else begin
        if (out_ready_i) out_vld_q <= 1'b0;
        if (take)        sat_q     <= sat_q || flags_i.sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && flags_i.pend) begin
      area_q       <= mag;
      vcnt_q       <= vcnt_i;
      selected_q   <= chosen;
      total_out_q  <= total_d;
      chosen_out_q <= chosen_d;
      seen_out_q   <= seen_d;
      final_q      <= flags_i.send;
      overflow_q   <= sat_q || event_sat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign area_o      = area_q;
  assign vcnt_o      = vcnt_q;
  assign selected_o  = selected_q;
  assign total_o     = total_out_q;
  assign chosen_o    = chosen_out_q;
  assign seen_o      = seen_out_q;
  assign final_o     = final_q;
  assign overflow_o  = overflow_q;

endmodule

[rtl/core/polygon_area_filter_sum.sv]
// Top level of the polygon area filter and sum: config registers and pipeline wiring.
// Depends on paf_pkg, paf_if, paf_cross, paf_accum and paf_total.
//
// Usage:
//   vtx_i carries one vertex per transaction (x, y, polygon_end, set_end). A vertex
//   with polygon_end closes its polygon and makes exactly one transaction on res_o;
//   other vertices make none. set_end is only looked at together with polygon_end
//   and clears the set totals after that result is reported with final_result.
//   cfg_i writes select_mode (index 0) and match_vertices (index 1); it is always
//   ready and should only be written while no vertex is in flight.
// Timing:
//   One vertex per cycle sustained while res_o accepts results. A closing vertex passes
//   the input register, product register, cross-term register, shoelace accumulator
//   and result register, in that order, on its way to res_o. The accumulator's saturating
//   add loop and the set-total add loop set the rate.
// Reset:
//   Pipeline empty, select_mode = all polygons, match_vertices = 3, totals, counts
//   and the overflow flag cleared; the next vertex starts a fresh polygon.
// Backpressure:
//   When res_o stalls, the result is held and vertices keep entering until the
//   pipeline stages fill; non-closing vertices drain past a held result.
module polygon_area_filter_sum #(
  parameter int unsigned COORD_BITS   = paf_pkg::COORD_BITS,
  parameter int unsigned MAX_VERTICES = paf_pkg::MAX_VERTICES,
  parameter int unsigned SUM_BITS     = paf_pkg::SUM_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  paf_in_if.sink   vtx_i,
  paf_cfg_if.sink  cfg_i,
  paf_out_if.source res_o
);

  localparam int unsigned CrossBits = 2 * COORD_BITS + 1;

  // Configuration registers
  paf_pkg::sel_mode_e                mode_q;
  logic [paf_pkg::VCNT_BITS-1:0]     match_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= paf_pkg::MODE_RESET;
      match_q <= paf_pkg::MATCH_RESET;
    end else if (cfg_i.valid) begin
      unique case (paf_pkg::cfg_reg_e'(cfg_i.index))
        paf_pkg::CFG_SELECT_MODE:
          mode_q <= paf_pkg::sel_mode_e'(cfg_i.data[paf_pkg::MODE_BITS-1:0]);
        paf_pkg::CFG_MATCH_VERTICES:
          match_q <= cfg_i.data[paf_pkg::VCNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front end -> accumulator
  logic                          x_valid, x_ready;
  paf_pkg::vtx_flags_t           x_flags;
  logic signed [CrossBits-1:0]   c_prev, c_close;

  // Accumulator -> totals
  logic                          a_valid, a_ready;
  paf_pkg::acc_flags_t           a_flags;
  logic signed [SUM_BITS-1:0]    a_sum;
  logic [paf_pkg::VCNT_BITS-1:0] a_vcnt;

  paf_cross #(
    .CoordBits (COORD_BITS)
  ) u_cross (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vtx_i.valid),
    .in_ready_o  (vtx_i.ready),
    .x_i         (vtx_i.x_coord),
    .y_i         (vtx_i.y_coord),
    .pend_i      (vtx_i.polygon_end),
    .send_i      (vtx_i.set_end),
    .out_valid_o (x_valid),
    .out_ready_i (x_ready),
    .flags_o     (x_flags),
    .c_prev_o    (c_prev),
    .c_close_o   (c_close)
  );

  paf_accum #(
    .CoordBits   (COORD_BITS),
    .SumBits     (SUM_BITS),
    .MaxVertices (MAX_VERTICES)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (x_valid),
    .in_ready_o  (x_ready),
    .flags_i     (x_flags),
    .c_prev_i    (c_prev),
    .c_close_i   (c_close),
    .out_valid_o (a_valid),
    .out_ready_i (a_ready),
    .flags_o     (a_flags),
    .sum_o       (a_sum),
    .vcnt_o      (a_vcnt)
  );

  paf_total #(
    .SumBits (SUM_BITS)
  ) u_total (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_valid),
    .in_ready_o  (a_ready),
    .flags_i     (a_flags),
    .sum_i       (a_sum),
    .vcnt_i      (a_vcnt),
    .mode_i      (mode_q),
    .match_i     (match_q),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .area_o      (res_o.polygon_double_area),
    .vcnt_o      (res_o.polygon_vertices),
    .selected_o  (res_o.polygon_selected),
    .total_o     (res_o.total_double_area),
    .chosen_o    (res_o.selected_total),
    .seen_o      (res_o.polygon_total),
    .final_o     (res_o.final_result),
    .overflow_o  (res_o.overflow_flag)
  );

endmodule
